// File: hw/rtl/assert_macros.svh
// assertion macros used by the framer back end
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// property must hold at every clock edge outside reset
`define ASSERT_AT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
// expression must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition seen");
`else
`define ASSERT_AT(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif

`endif

// File: hw/rtl/rfmc_pkg.sv
// types, constants and crc helpers for the record framer
`default_nettype none

package rfmc_pkg;

    localparam logic [31:0] CRC_POLY = 32'h82F6_3B78;
    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
    localparam logic [31:0] MASK_ADD = 32'hA282_EAD8;

    // input opcodes
    localparam logic OP_START = 1'b0;
    localparam logic OP_DATA  = 1'b1;

    // status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_MISMATCH = 2'd1;
    localparam logic [1:0] ST_NOSTART  = 2'd2;

    typedef struct packed {
        logic        opcode;
        logic [63:0] payload_length;
        logic [7:0]  data_byte;
        logic        final_byte;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_end;
        logic       record_end;
        logic [1:0] status;
    } out_item_t;

    typedef enum logic [1:0] {
        JOB_START = 2'd0,
        JOB_DATA  = 2'd1,
        JOB_ERR   = 2'd2
    } job_kind_t;

    // one classified item handed from front to back
    typedef struct packed {
        job_kind_t   kind;
        logic [63:0] len;
        logic [7:0]  data;
        logic [31:0] crc;
        logic [1:0]  status;
        logic        footer;
    } job_t;

    // one reflected crc-32c byte step
    function automatic logic [31:0] crc_fold(input logic [31:0] c_in, input logic [7:0] b);
        logic [31:0] c;
        c = c_in ^ {24'h00_0000, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    // final inversion, rotate right by 15, add constant
    function automatic logic [31:0] mask_crc(input logic [31:0] crc_in);
        logic [31:0] v;
        v = ~crc_in;
        return {v[14:0], v[31:15]} + MASK_ADD;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/rfmc_front.sv
// front end: accepts items, keeps record state, classifies into jobs
`default_nettype none

module rfmc_front (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  rfmc_pkg::in_item_t      s_data,
    output logic                    job_valid,
    input  wire logic               job_ready,
    output rfmc_pkg::job_t          job_data
);
    import rfmc_pkg::*;

    logic [31:0] crc_reg,    crc_next;
    logic [63:0] seen_reg,   seen_next;
    logic [63:0] expect_reg, expect_next;
    logic        open_reg,   open_next;

    logic        accept;
    logic [31:0] crc_fold_val;
    logic [63:0] seen_inc;

    assign s_ready   = job_ready;
    assign job_valid = s_valid;
    assign accept    = s_valid && job_ready;

    assign crc_fold_val = crc_fold(crc_reg, s_data.data_byte);
    assign seen_inc     = seen_reg + 64'd1;

    // classify the beat and work out the next record state
    always_comb begin
        crc_next         = crc_reg;
        seen_next        = seen_reg;
        expect_next      = expect_reg;
        open_next        = open_reg;
        job_data.kind    = JOB_ERR;
        job_data.len     = s_data.payload_length;
        job_data.data    = s_data.data_byte;
        job_data.crc     = CRC_INIT;
        job_data.status  = ST_NOSTART;
        job_data.footer  = 1'b0;
        priority if (s_data.opcode == OP_START) begin
            job_data.kind   = JOB_START;
            job_data.status = ST_OK;
            job_data.footer = (s_data.payload_length == 64'd0);
            crc_next        = CRC_INIT;
            seen_next       = 64'd0;
            expect_next     = s_data.payload_length;
            open_next       = (s_data.payload_length != 64'd0);
        end else if (!open_reg) begin
            job_data.kind   = JOB_ERR;
        end else if (s_data.final_byte) begin
            job_data.kind   = JOB_DATA;
            job_data.crc    = crc_fold_val;
            job_data.status = (seen_inc != expect_reg) ? ST_MISMATCH : ST_OK;
            job_data.footer = 1'b1;
            crc_next        = CRC_INIT;
            seen_next       = 64'd0;
            open_next       = 1'b0;
        end else begin
            job_data.kind   = JOB_DATA;
            job_data.status = ST_OK;
            crc_next        = crc_fold_val;
            seen_next       = seen_inc;
        end
    end

    // record state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_reg    <= CRC_INIT;
            seen_reg   <= 64'd0;
            expect_reg <= 64'd0;
            open_reg   <= 1'b0;
        end else if (accept) begin
            crc_reg    <= crc_next;
            seen_reg   <= seen_next;
            expect_reg <= expect_next;
            open_reg   <= open_next;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/rfmc_queue.sv
// short job queue between front and back end
`default_nettype none

module rfmc_queue #(
    parameter int DEPTH = 2
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  rfmc_pkg::job_t      in_data,
    output logic                out_valid,
    input  wire logic           out_ready,
    output rfmc_pkg::job_t      out_data
);
    import rfmc_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    job_t            slot_reg [DEPTH];
    logic [AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg,  count_next;
    logic            push, pop;

    assign in_ready  = (count_reg != FULL_CNT);
    assign out_valid = (count_reg != '0);
    assign out_data  = slot_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    // pointer and fill count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + AW'(1);
        end
        unique case ({push, pop})
            2'b10:   count_next = count_reg + CW'(1);
            2'b01:   count_next = count_reg - CW'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // slot storage
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/rfmc_back.sv
// back end: serializes jobs into header, payload and footer beats
`default_nettype none
`include "assert_macros.svh"

module rfmc_back (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           job_valid,
    output logic                job_ready,
    input  rfmc_pkg::job_t      job_data,
    output logic                m_valid,
    input  wire logic           m_ready,
    output rfmc_pkg::out_item_t m_data
);
    import rfmc_pkg::*;

    typedef enum logic [3:0] {
        BK_IDLE = 4'b0001,
        BK_HDR  = 4'b0010,
        BK_HCRC = 4'b0100,
        BK_FOOT = 4'b1000
    } back_state_t;

    back_state_t state_reg,  state_next;
    logic [2:0]  cnt_reg,    cnt_next;
    logic [63:0] len_reg,    len_next;
    logic [31:0] hcrc_reg,   hcrc_next;
    logic [31:0] crc_reg,    crc_next;
    logic [1:0]  st_reg,     st_next;
    logic        footer_reg, footer_next;
    out_item_t   out_reg,    out_next;
    logic        ovalid_reg, ovalid_next;

    logic        out_free;
    logic [31:0] mask_word;
    logic [7:0]  mask_byte;
    logic        cnt_last4;

    assign out_free  = !ovalid_reg || m_ready;
    assign mask_word = mask_crc((state_reg == BK_HCRC) ? hcrc_reg : crc_reg);
    assign mask_byte = mask_word[{cnt_reg[1:0], 3'b000} +: 8];
    assign cnt_last4 = (cnt_reg[1:0] == 2'd3);
    assign m_valid   = ovalid_reg;
    assign m_data    = out_reg;

    // sequencer: one output beat per free cycle
    always_comb begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        len_next    = len_reg;
        hcrc_next   = hcrc_reg;
        crc_next    = crc_reg;
        st_next     = st_reg;
        footer_next = footer_reg;
        out_next    = out_reg;
        ovalid_next = ovalid_reg && !m_ready;
        job_ready   = 1'b0;
        if (out_free) begin
            unique case (state_reg)
                BK_IDLE: begin
                    if (job_valid) begin
                        job_ready   = 1'b1;
                        ovalid_next = 1'b1;
                        crc_next    = job_data.crc;
                        st_next     = job_data.status;
                        footer_next = job_data.footer;
                        unique case (job_data.kind)
                            JOB_START: begin
                                out_next  = '{out_byte: job_data.len[7:0], run_end: 1'b0,
                                              record_end: 1'b0, status: ST_OK};
                                len_next  = job_data.len >> 8;
                                hcrc_next = crc_fold(CRC_INIT, job_data.len[7:0]);
                                cnt_next  = 3'd1;
                                state_next = BK_HDR;
                            end
                            JOB_DATA: begin
                                out_next = '{out_byte: job_data.data,
                                             run_end: !job_data.footer,
                                             record_end: 1'b0, status: job_data.status};
                                cnt_next = 3'd0;
                                if (job_data.footer) begin
                                    state_next = BK_FOOT;
                                end
                            end
                            default: begin
                                out_next = '{out_byte: 8'h00, run_end: 1'b1,
                                             record_end: 1'b0, status: ST_NOSTART};
                            end
                        endcase
                    end
                end
                BK_HDR: begin
                    ovalid_next = 1'b1;
                    out_next    = '{out_byte: len_reg[7:0], run_end: 1'b0,
                                    record_end: 1'b0, status: ST_OK};
                    len_next    = len_reg >> 8;
                    hcrc_next   = crc_fold(hcrc_reg, len_reg[7:0]);
                    cnt_next    = cnt_reg + 3'd1;
                    if (cnt_reg == 3'd7) begin
                        state_next = BK_HCRC;
                    end
                end
                BK_HCRC: begin
                    ovalid_next = 1'b1;
                    out_next    = '{out_byte: mask_byte, run_end: cnt_last4 && !footer_reg,
                                    record_end: 1'b0, status: ST_OK};
                    cnt_next    = cnt_last4 ? 3'd0 : cnt_reg + 3'd1;
                    if (cnt_last4) begin
                        state_next = footer_reg ? BK_FOOT : BK_IDLE;
                    end
                end
                BK_FOOT: begin
                    ovalid_next = 1'b1;
                    out_next    = '{out_byte: mask_byte, run_end: cnt_last4,
                                    record_end: cnt_last4, status: st_reg};
                    cnt_next    = cnt_last4 ? 3'd0 : cnt_reg + 3'd1;
                    if (cnt_last4) begin
                        state_next = BK_IDLE;
                    end
                end
                default: begin
                    state_next = BK_IDLE;
                end
            endcase
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= BK_IDLE;
            cnt_reg    <= 3'd0;
            ovalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            ovalid_reg <= ovalid_next;
        end
    end

    // working and output payload registers
    always_ff @(posedge aclk) begin
        len_reg    <= len_next;
        hcrc_reg   <= hcrc_next;
        crc_reg    <= crc_next;
        st_reg     <= st_next;
        footer_reg <= footer_next;
        out_reg    <= out_next;
    end

    // a job is taken only between serialized runs
    `ASSERT_AT(a_pop_idle, aclk, aresetn, job_ready |-> (state_reg == BK_IDLE))
    // crc byte index stays within a 32-bit word
    `ASSERT_AT(a_crc_idx, aclk, aresetn,
        (state_reg == BK_HCRC || state_reg == BK_FOOT) |-> (cnt_reg[2] == 1'b0))
    // a record end always closes the run of its item
    `ASSERT_NEVER(a_rec_run, aclk, aresetn, m_valid && m_data.record_end && !m_data.run_end)
    // header length bytes lead into the header crc
    `ASSERT_AT(a_hdr_seq, aclk, aresetn,
        (state_reg == BK_HDR && cnt_reg == 3'd7 && out_free) |=> (state_reg == BK_HCRC))

endmodule

`default_nettype wire

// File: hw/rtl/record_framer_masked_crc32c_unit.sv
// top level of the record framer with masked crc-32c
`default_nettype none

// Record framer: each start beat yields 8 little-endian length bytes and 4 bytes of
// masked crc-32c over them (12 output beats, 16 for a zero-length record with its
// empty footer); each data beat yields its byte, plus the 4-byte masked payload crc
// footer on the final byte (5 beats). Output runs at one beat per cycle while m_ready
// allows, so data bytes then sustain one item per cycle; a start item or a final
// byte holds the output until all of its beats are out. The QUEUE_DEPTH-entry job
// queue lets the front end keep accepting items while the back end serializes a
// header or footer. No clearing pass after reset.
module record_framer_masked_crc32c_unit #(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  rfmc_pkg::in_item_t      s_data,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output rfmc_pkg::out_item_t     m_data
);
    import rfmc_pkg::*;

    logic fq_valid, fq_ready;
    job_t fq_data;
    logic qb_valid, qb_ready;
    job_t qb_data;

    rfmc_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .job_valid (fq_valid),
        .job_ready (fq_ready),
        .job_data  (fq_data)
    );

    rfmc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_data   (fq_data),
        .out_valid (qb_valid),
        .out_ready (qb_ready),
        .out_data  (qb_data)
    );

    rfmc_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .job_valid (qb_valid),
        .job_ready (qb_ready),
        .job_data  (qb_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

`default_nettype wire

// File: tb/sv/testbench.sv
// self-checking testbench for the record framer with masked crc-32c
`default_nettype none

module testbench;
    import rfmc_pkg::*;

    localparam int IDLE_LIMIT   = 1000;
    localparam int TAIL_CYCLES  = 32;
    localparam int RANDOM_ITEMS = 76;
    localparam int MAX_REPORTS  = 20;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_data;

    record_framer_masked_crc32c_unit u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // clock, period 8
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // framer state as the testbench tracks it
    logic [31:0] payload_crc;
    logic [63:0] declared_len;
    logic [63:0] payload_count;
    logic        record_open;

    // framed stream beats still due from the block
    out_item_t framed_bytes_q[$];

    int fail_count     = 0;
    int items_sent     = 0;
    int beats_checked  = 0;
    int records_closed = 0;
    int mismatch_recs  = 0;
    int orphan_bytes   = 0;
    int burst_left     = 0;
    int idle_cycles    = 0;

    // one reflected crc-32c step, polynomial 0x82f63b78
    function automatic logic [31:0] crc32c_byte(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] r;
        logic        fb;
        r = c;
        for (int i = 0; i < 8; i++) begin
            fb = r[0] ^ b[i];
            r  = {1'b0, r[31:1]};
            if (fb) begin
                r = r ^ 32'h82F6_3B78;
            end
        end
        return r;
    endfunction

    // invert, rotate right by 15, add the mask constant
    function automatic logic [31:0] crc32c_mask(input logic [31:0] c);
        logic [31:0] v;
        v = c ^ 32'hFFFF_FFFF;
        return ((v >> 15) | (v << 17)) + MASK_ADD;
    endfunction

    function automatic out_item_t make_beat(input logic [7:0] b, input logic [1:0] st,
                                            input logic rec_end);
        out_item_t r;
        r.out_byte   = b;
        r.run_end    = 1'b0;
        r.record_end = rec_end;
        r.status     = st;
        return r;
    endfunction

    function automatic in_item_t start_item(input logic [63:0] len);
        in_item_t it;
        it.opcode         = OP_START;
        it.payload_length = len;
        it.data_byte      = 8'($urandom);
        it.final_byte     = 1'($urandom);
        return it;
    endfunction

    function automatic in_item_t data_item(input logic [7:0] b, input logic fin);
        in_item_t it;
        it.opcode         = OP_DATA;
        it.payload_length = {$urandom, $urandom};
        it.data_byte      = b;
        it.final_byte     = fin;
        return it;
    endfunction

    // work out the framed beats one accepted item causes
    task automatic frame_item(input in_item_t it);
        out_item_t   res[16];
        int          n;
        logic [31:0] hdr_crc;
        logic [31:0] tag;
        logic [1:0]  st;
        n = 0;
        if (it.opcode == OP_START) begin
            hdr_crc = 32'hFFFF_FFFF;
            for (int i = 0; i < 8; i++) begin
                hdr_crc = crc32c_byte(hdr_crc, it.payload_length[8*i +: 8]);
                res[n] = make_beat(it.payload_length[8*i +: 8], ST_OK, 1'b0);
                n++;
            end
            tag = crc32c_mask(hdr_crc);
            for (int i = 0; i < 4; i++) begin
                res[n] = make_beat(tag[8*i +: 8], ST_OK, 1'b0);
                n++;
            end
            // a start drops whatever record was open
            payload_crc   = 32'hFFFF_FFFF;
            payload_count = '0;
            declared_len  = it.payload_length;
            record_open   = (it.payload_length != 0);
            if (it.payload_length == 0) begin
                tag = crc32c_mask(payload_crc);
                for (int i = 0; i < 4; i++) begin
                    res[n] = make_beat(tag[8*i +: 8], ST_OK, i == 3);
                    n++;
                end
                records_closed++;
            end
        end else if (!record_open) begin
            res[n] = make_beat(8'h00, ST_NOSTART, 1'b0);
            n++;
            orphan_bytes++;
        end else begin
            payload_crc   = crc32c_byte(payload_crc, it.data_byte);
            payload_count = payload_count + 64'd1;
            if (it.final_byte) begin
                st = (payload_count != declared_len) ? ST_MISMATCH : ST_OK;
                res[n] = make_beat(it.data_byte, st, 1'b0);
                n++;
                tag = crc32c_mask(payload_crc);
                for (int i = 0; i < 4; i++) begin
                    res[n] = make_beat(tag[8*i +: 8], st, i == 3);
                    n++;
                end
                payload_crc   = 32'hFFFF_FFFF;
                payload_count = '0;
                record_open   = 1'b0;
                records_closed++;
                if (st == ST_MISMATCH) begin
                    mismatch_recs++;
                end
            end else begin
                res[n] = make_beat(it.data_byte, ST_OK, 1'b0);
                n++;
            end
        end
        res[n-1].run_end = 1'b1;
        for (int i = 0; i < n; i++) begin
            framed_bytes_q.push_back(res[i]);
        end
    endtask

    // present one beat, with burst gaps, and wait until it is taken
    task automatic send_item(input in_item_t it);
        int gap;
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = $urandom_range(1, 16);
            if (gap > 0) begin
                @(negedge aclk);
                s_valid <= 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
        end
        burst_left--;
        @(negedge aclk);
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!s_ready);
        frame_item(it);
        items_sent++;
    endtask

    // hold off the sender until every due beat has come out
    task automatic wait_drained();
        @(negedge aclk);
        s_valid <= 1'b0;
        burst_left = 0;
        while (framed_bytes_q.size() != 0) @(posedge aclk);
    endtask

    task automatic send_record(input logic [63:0] len, input int nbytes);
        send_item(start_item(len));
        for (int i = 0; i < nbytes; i++) begin
            send_item(data_item(8'($urandom), i == nbytes - 1));
        end
    endtask

    // length field extremes and the empty record
    task automatic test_header_lengths();
        send_item(start_item(64'd0));
        send_item(start_item(64'hFFFF_FFFF_FFFF_FFFF));
        send_item(start_item(64'hA5A5_A5A5_A5A5_A5A5));
        send_item(start_item(64'h5A5A_5A5A_5A5A_5A5A));
        send_item(start_item(64'h8000_0000_0000_0001));
        send_item(start_item(64'd0));
        wait_drained();
    endtask

    // well-formed records with byte extremes
    task automatic test_payload_records();
        send_item(start_item(64'd1));
        send_item(data_item(8'h00, 1'b1));
        send_item(start_item(64'd3));
        send_item(data_item(8'hFF, 1'b0));
        send_item(data_item(8'h80, 1'b0));
        send_item(data_item(8'h01, 1'b1));
        wait_drained();
    endtask

    // orphan data, early and late final, abandoned record
    task automatic test_framing_errors();
        send_item(data_item(8'hFF, 1'b1));
        send_item(data_item(8'h7E, 1'b0));
        send_item(start_item(64'd4));
        send_item(data_item(8'h55, 1'b1));
        send_item(start_item(64'd2));
        send_item(data_item(8'hAA, 1'b0));
        send_item(data_item(8'h0F, 1'b0));
        send_item(data_item(8'hF0, 1'b1));
        send_item(start_item(64'd5));
        send_item(data_item(8'h3C, 1'b0));
        send_item(start_item(64'd1));
        send_item(data_item(8'hC3, 1'b1));
        wait_drained();
    endtask

    // mostly well-formed records with random content, some noise
    task automatic test_random_stream();
        int start_count;
        int kind;
        int len;
        start_count = items_sent;
        while (items_sent - start_count < RANDOM_ITEMS) begin
            kind = $urandom_range(0, 19);
            len  = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 6);
            if (kind < 13) begin
                send_record(64'(len), len);
            end else if (kind == 13) begin
                send_record(64'd0, 0);
            end else if (kind == 14) begin
                send_item(data_item(8'($urandom), 1'($urandom)));
            end else if (kind == 15) begin
                // final mark before the count is reached
                send_record(64'(len + 1), $urandom_range(1, len));
            end else if (kind == 16) begin
                // count runs past the length before the final mark
                send_record(64'(len), len + $urandom_range(1, 3));
            end else if (kind == 17) begin
                // random wide length, closed early
                send_record({$urandom, $urandom} | 64'd1, $urandom_range(1, 4));
            end else begin
                // record abandoned by a new start
                send_item(start_item(64'(len + 1)));
                for (int i = 0; i < len; i++) begin
                    send_item(data_item(8'($urandom), 1'b0));
                end
            end
            if ($urandom_range(0, 9) == 0) begin
                wait_drained();
            end
        end
        wait_drained();
    endtask

    // receiver ready pattern, reloaded now and then
    logic [15:0] ready_pattern = 16'hFFFF;
    int          pattern_left  = 0;
    always @(negedge aclk) begin
        if (pattern_left == 0) begin
            pattern_left <= $urandom_range(30, 120);
            case ($urandom_range(0, 3))
                0: begin
                    ready_pattern <= 16'hFFFF;
                end
                1: begin
                    ready_pattern <= 16'($urandom) | 16'h0001;
                end
                2: begin
                    ready_pattern <= 16'h0001 << $urandom_range(0, 15);
                end
                default: begin
                    ready_pattern <= ~(16'h0001 << $urandom_range(0, 15));
                end
            endcase
        end else begin
            pattern_left  <= pattern_left - 1;
            ready_pattern <= {ready_pattern[0], ready_pattern[15:1]};
        end
        m_ready <= ready_pattern[0];
    end

    // compare each output beat with the oldest due beat
    always @(posedge aclk) begin
        out_item_t due;
        logic      bad;
        if (aresetn && m_valid && m_ready) begin
            if (framed_bytes_q.size() == 0) begin
                fail_count++;
                if (fail_count <= MAX_REPORTS) begin
                    $display("%0t: unexpected beat byte %02h run_end %b record_end %b status %0d",
                             $time, m_data.out_byte, m_data.run_end, m_data.record_end,
                             m_data.status);
                end
            end else begin
                due = framed_bytes_q.pop_front();
                bad = (m_data.out_byte !== due.out_byte) || (m_data.run_end !== due.run_end)
                    || (m_data.record_end !== due.record_end) || (m_data.status !== due.status);
                if (bad) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS) begin
                        $display("%0t: beat %0d expected byte %02h run_end %b record_end %b",
                                 $time, beats_checked, due.out_byte, due.run_end,
                                 due.record_end,
                                 " status %0d, actual byte %02h run_end %b record_end %b",
                                 due.status, m_data.out_byte, m_data.run_end,
                                 m_data.record_end, " status %0d", m_data.status);
                    end
                end
                beats_checked++;
            end
        end
    end

    // watchdog on cycles with no beat moving on either side
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no progress for %0d cycles, %0d beats still due",
                     $time, idle_cycles, framed_bytes_q.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        payload_crc   = 32'hFFFF_FFFF;
        declared_len  = '0;
        payload_count = '0;
        record_open   = 1'b0;
        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;

        test_header_lengths();
        test_payload_records();
        test_framing_errors();
        test_random_stream();

        repeat (TAIL_CYCLES) @(posedge aclk);
        if (framed_bytes_q.size() != 0) begin
            fail_count++;
            $display("%0t: %0d beats never came out", $time, framed_bytes_q.size());
        end
        $display("run: %0d items in, %0d beats checked, %0d records closed",
                 items_sent, beats_checked, records_closed);
        $display("     %0d with length mismatch, %0d data beats outside a record",
                 mismatch_recs, orphan_bytes);
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire

// File: sim.f
+incdir+hw/rtl
hw/rtl/rfmc_pkg.sv
hw/rtl/rfmc_front.sv
hw/rtl/rfmc_queue.sv
hw/rtl/rfmc_back.sv
hw/rtl/record_framer_masked_crc32c_unit.sv
tb/sv/testbench.sv
